// File: src/rmt_pkg.sv
// shared constants and opcodes for the range maximum tree
`default_nettype none
package rmt_pkg;

  // field widths of the request and result
  localparam int OP_W    = 2;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 64;

  // default number of leaves
  localparam int LEAVES_DEFAULT = 1024;

  // request opcodes
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

endpackage
`default_nettype wire

// File: src/rmt_if.sv
// request and result channel interfaces of the range maximum tree
`default_nettype none
interface rmt_in_if import rmt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic [INDEX_W-1:0]        index_lo;
  logic [INDEX_W-1:0]        index_hi;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output opcode, output index_lo, output index_hi,
                  output value, input ready);
  modport sink (input valid, input opcode, input index_lo, input index_hi,
                input value, output ready);
endinterface

interface rmt_out_if import rmt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] max_value;
  logic [INDEX_W-1:0]        max_index;

  modport source (output valid, output max_value, output max_index, input ready);
  modport sink (input valid, input max_value, input max_index, output ready);
endinterface
`default_nettype wire

// File: src/rmt_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module rmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/range_max_tree_extract.sv
// range maximum segment tree with point write, range query and extract
//
// Requests arrive on req (valid/ready), one at a time. A write stores a signed
// value at a leaf and recombines its ancestors; a query returns the maximum
// over an inclusive leaf range with its leaf index; an extract answers like a
// query and then writes zero at the leaf it found. Results leave on rsp from
// an output register, one per query or extract, none for a write.
//
// The tree lives in one ram of 2*LEAVES entries with a single read port, so
// every node visited costs a read. A write stores the leaf and then, for each
// of the L tree levels above it (about log2(LEAVES)), reads the sibling and
// writes the parent. A query takes a step and up to two border reads per level,
// then reads the last node and loads the result register; an extract adds a
// write walk.
//
// After reset the block clears the ram, one entry a cycle, over all 2*LEAVES
// entries with req.ready low. If the receiver stalls, the pending result
// stays in the output register; the next request is still taken and only its
// own result waits until the register is free.
`default_nettype none
module range_max_tree_extract import rmt_pkg::*; #(
  parameter int LEAVES = LEAVES_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  rmt_in_if.sink   req,
  rmt_out_if.source rsp
);

  localparam int NODES = 2 * LEAVES;
  localparam int NW    = $clog2(NODES);
  localparam int LW    = $clog2(LEAVES);
  localparam int EW    = LW + VALUE_W;
  localparam logic [31:0] LEAVES_U = 32'(LEAVES);
  localparam logic [NW-1:0] LEAF_BASE = NW'(LEAVES);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [NW-1:0] ROOT      = NW'(1);

  // sequencer states
  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LEAF  = 3'd2;
  localparam logic [2:0] S_URD   = 3'd3;
  localparam logic [2:0] S_UWR   = 3'd4;
  localparam logic [2:0] S_QSTEP = 3'd5;
  localparam logic [2:0] S_QTAKE = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]    state;
  logic [NW-1:0] n;
  logic [NW-1:0] qi;
  logic [NW-1:0] qj;
  logic          take_j;
  logic          take_final;
  logic          ext;
  logic [LW-1:0] leaf;
  logic signed [VALUE_W-1:0] val;
  logic [EW-1:0] cur;
  logic signed [VALUE_W-1:0] best;
  logic [LW-1:0] where_leaf;
  logic          ov;
  logic signed [VALUE_W-1:0] out_value;
  logic [INDEX_W-1:0]        out_index;

  // ram ports
  logic          ram_we;
  logic [NW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [NW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  rmt_ram #(.WIDTH(EW), .DEPTH(NODES)) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request decode
  logic          accept;
  logic          lo_ok;
  logic [31:0]   hi_clamped;
  logic [LW-1:0] lo_leaf;
  logic [NW-1:0] lo_node;
  logic [NW-1:0] hi_node;
  logic          range_ok;

  assign accept     = req.valid && req.ready;
  assign lo_ok      = 32'(req.index_lo) < LEAVES_U;
  assign hi_clamped = (32'(req.index_hi) >= LEAVES_U) ? (LEAVES_U - 32'd1)
                                                       : 32'(req.index_hi);
  assign lo_leaf    = LW'(32'(req.index_lo));
  assign lo_node    = NW'(32'(req.index_lo) + LEAVES_U);
  assign hi_node    = NW'(hi_clamped + LEAVES_U);
  assign range_ok   = lo_ok && (32'(req.index_lo) <= hi_clamped);

  // fields of the entry just read
  logic [LW-1:0]             rd_leaf;
  logic signed [VALUE_W-1:0] rd_val;
  assign rd_leaf = ram_rdata[EW-1:VALUE_W];
  assign rd_val  = $signed(ram_rdata[VALUE_W-1:0]);

  // parent recombine: the tie goes to the left child
  logic [EW-1:0]             left_e;
  logic [EW-1:0]             right_e;
  logic [EW-1:0]             par_e;
  logic signed [VALUE_W-1:0] left_v;
  logic signed [VALUE_W-1:0] right_v;
  always_comb begin
    left_e  = n[0] ? ram_rdata : cur;
    right_e = n[0] ? cur : ram_rdata;
    left_v  = $signed(left_e[VALUE_W-1:0]);
    right_v = $signed(right_e[VALUE_W-1:0]);
    par_e   = (left_v < right_v) ? right_e : left_e;
  end

  // walk take: replace only on a strictly greater value
  logic take_hit;
  assign take_hit = best < rd_val;

  // result register can be loaded
  logic out_free;
  logic out_load;
  assign out_free = !ov || rsp.ready;
  assign out_load = (state == S_EMIT) && out_free;

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_load) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  // ram address and write selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n;
    ram_wdata = '0;
    ram_raddr = qi;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = n;
        ram_wdata = '0;
      end
      S_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = NW'(leaf) + LEAF_BASE;
        ram_wdata = {leaf, val};
      end
      S_URD: begin
        ram_raddr = n ^ ROOT;
      end
      S_UWR: begin
        ram_we    = 1'b1;
        ram_waddr = n >> 1;
        ram_wdata = par_e;
      end
      S_QSTEP: begin
        if (qi < qj) begin
          ram_raddr = qi[0] ? qi : qj;
        end else begin
          ram_raddr = qi;
        end
      end
      S_QTAKE: begin
        ram_raddr = qj;
      end
      default: begin
        ram_raddr = qi;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      n     <= '0;
    end else begin
      case (state)
        S_CLR: begin
          n <= n + NW'(1);
          if (n == LAST_NODE) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              OP_WRITE: begin
                leaf <= lo_leaf;
                val  <= req.value;
                if (lo_ok) begin
                  state <= S_LEAF;
                end
              end
              OP_QUERY, OP_EXTRACT: begin
                ext        <= (req.opcode == OP_EXTRACT);
                best       <= '0;
                where_leaf <= '0;
                qi         <= lo_node;
                qj         <= hi_node;
                state      <= range_ok ? S_QSTEP : S_EMIT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LEAF: begin
          n     <= NW'(leaf) + LEAF_BASE;
          cur   <= {leaf, val};
          state <= S_URD;
        end
        S_URD: begin
          state <= S_UWR;
        end
        S_UWR: begin
          cur <= par_e;
          n   <= n >> 1;
          state <= ((n >> 1) == ROOT) ? S_IDLE : S_URD;
        end
        S_QSTEP: begin
          // a right border read in S_QTAKE follows only when the left one was taken
          take_final <= (qi == qj);
          take_j     <= !qi[0];
          if (qi < qj) begin
            if (qi[0]) begin
              // left border node first
              qi     <= qi + NW'(1);
              state  <= S_QTAKE;
            end else if (!qj[0]) begin
              qj     <= qj - NW'(1);
              state  <= S_QTAKE;
            end else begin
              qi <= qi >> 1;
              qj <= qj >> 1;
            end
          end else if (qi == qj) begin
            state      <= S_QTAKE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_QTAKE: begin
          if (take_hit) begin
            best       <= rd_val;
            where_leaf <= rd_leaf;
          end
          if (take_final) begin
            state <= S_EMIT;
          end else if (!take_j && !qj[0]) begin
            // right border node read issued this cycle
            qj     <= qj - NW'(1);
            take_j <= 1'b1;
          end else begin
            qi    <= qi >> 1;
            qj    <= qj >> 1;
            state <= S_QSTEP;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_value <= best;
            out_index <= INDEX_W'(32'(where_leaf));
            if (ext) begin
              leaf  <= where_leaf;
              val   <= '0;
              state <= S_LEAF;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = ov;
  assign rsp.max_value = out_value;
  assign rsp.max_index = out_index;

  // no request is taken while the tree is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !req.ready)
    else $error("request accepted during clear");

  // the walk starts at zero, so a result is never negative
  a_result_nonneg: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !rsp.max_value[VALUE_W-1])
    else $error("negative range maximum");

  // node zero is never part of the tree outside the clear pass
  a_no_node_zero: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state != S_CLR)) |-> (ram_waddr != '0))
    else $error("write to unused node zero");

  // the border nodes cross by at most one
  a_border_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_QSTEP) |-> ({1'b0, qi} <= ({1'b0, qj} + (NW+1)'(1))))
    else $error("range walk borders crossed");

  // a result is only loaded once the register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ov && !rsp.ready && state == S_EMIT) |=> $stable(out_value))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
